// ===== rtl/core/fletcher_framed_packet_receiver_core_defines.svh =====
// Assertion macros shared by the checker of the framed packet receiver core.
// Holds macro definitions only; no other dependencies.
`ifndef FLETCHER_FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FLETCHER_FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FFPR_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffpr check failed");

// Next-cycle implication, disabled while reset is high.
`define FFPR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffpr check failed");

// Next-cycle implication that also holds across reset.
`define FFPR_ASSERT_ALWAYS_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ffpr check failed");

`endif

// ===== rtl/core/ffpr_pkg.sv =====
// Shared types and constants of the framed packet receiver core.
// No dependencies; used by the controller, the datapath and the top level.
package ffpr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam int BYTE_W = 8;
   localparam int FRAME_LENGTH_W = 6;
   localparam int BYTE_INDEX_W = 5;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] START_FIRST_RESET = 8'd188;
   localparam logic [BYTE_W-1:0] START_SECOND_RESET = 8'd207;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 1'b1;

   typedef enum logic [3:0] {
      ST_START1,
      ST_START2,
      ST_TYPE,
      ST_LENGTH,
      ST_DATA,
      ST_CHECK1,
      ST_CHECK2,
      ST_EMIT_RD,
      ST_EMIT_WR
   } ctrl_state_type;

   typedef struct packed {
      logic take_type;
      logic take_length;
      logic take_data;
      logic emit_start;
      logic emit_next;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic start1_match;
      logic start2_match;
      logic len_too_big;
      logic len_zero;
      logic data_done;
      logic check1_ok;
      logic check2_ok;
      logic held_zero;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/ffpr_ctrl.sv =====
// Frame parsing and result emission state machine of the receiver core.
// Depends on ffpr_pkg for the state, command and status types.
module ffpr_ctrl
   import ffpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           req_accept;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_START1: begin
            if (req_accept && status.start1_match) state_in = ST_START2;
         end
         ST_START2: begin
            if (req_accept) state_in = status.start2_match ? ST_TYPE : ST_START1;
         end
         ST_TYPE: begin
            if (req_accept) state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            if (req_accept) begin
               priority if (status.len_too_big) state_in = ST_START1;
               else if (status.len_zero) state_in = ST_CHECK1;
               else state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (req_accept && status.data_done) state_in = ST_CHECK1;
         end
         ST_CHECK1: begin
            if (req_accept) state_in = status.check1_ok ? ST_CHECK2 : ST_START1;
         end
         ST_CHECK2: begin
            if (req_accept) begin
               priority if (!status.check2_ok) state_in = ST_START1;
               else if (status.held_zero) state_in = ST_EMIT_WR;
               else state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (status.out_free) state_in = status.emit_last ? ST_START1 : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_START1;
         end
      endcase
   end

   always_comb begin
      req_stall = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_WR);
      cmd = '0;
      unique case (state_ff)
         ST_TYPE: begin
            cmd.take_type = req_accept;
         end
         ST_LENGTH: begin
            cmd.take_length = req_accept && !status.len_too_big;
         end
         ST_DATA: begin
            cmd.take_data = req_accept;
         end
         ST_CHECK2: begin
            cmd.emit_start = req_accept && status.check2_ok;
         end
         ST_EMIT_WR: begin
            cmd.load_out = status.out_free;
            cmd.emit_next = status.out_free && !status.emit_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/ffpr_datapath.sv =====
// Datapath of the receiver core: start bytes, frame fields, Fletcher-8 sums,
// payload memory and the result register. Depends on ffpr_pkg.
module ffpr_datapath
   import ffpr_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [BYTE_W-1:0]         csr_data,
   input  logic [BYTE_W-1:0]         req_rx_byte,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [BYTE_W-1:0]         rsp_frame_type,
   output logic [FRAME_LENGTH_W-1:0] rsp_frame_length,
   output logic [BYTE_INDEX_W-1:0]   rsp_byte_index,
   output logic [BYTE_W-1:0]         rsp_payload_byte,
   output logic                      rsp_has_payload,
   output logic                      rsp_last
);

   localparam int LenW = $clog2(MaxPayload + 1);
   localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

   logic [BYTE_W-1:0] start_first_ff;
   logic [BYTE_W-1:0] start_second_ff;
   logic [BYTE_W-1:0] held_type_ff;
   logic [LenW-1:0]   held_length_ff;
   logic [LenW-1:0]   taken_ff;
   logic [BYTE_W-1:0] sum_low_ff;
   logic [BYTE_W-1:0] sum_high_ff;
   logic [BYTE_W-1:0] sum_low_in;
   logic [BYTE_W-1:0] sum_high_in;
   logic [LenW-1:0]   emit_idx_ff;
   logic              empty_ff;
   logic [BYTE_W-1:0] store [MaxPayload];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [LenW:0]     taken_next;
   logic [LenW:0]     emit_next_idx;
   logic [31:0]       len_ext;
   logic [31:0]       idx_ext;

   logic                      rsp_valid_ff;
   logic [BYTE_W-1:0]         rsp_frame_type_ff;
   logic [FRAME_LENGTH_W-1:0] rsp_frame_length_ff;
   logic [BYTE_INDEX_W-1:0]   rsp_byte_index_ff;
   logic [BYTE_W-1:0]         rsp_payload_byte_ff;
   logic                      rsp_has_payload_ff;
   logic                      rsp_last_ff;

   assign sum_low_in = sum_low_ff + req_rx_byte;
   assign sum_high_in = sum_high_ff + sum_low_in;
   assign taken_next = {1'b0, taken_ff} + {{LenW{1'b0}}, 1'b1};
   assign emit_next_idx = {1'b0, emit_idx_ff} + {{LenW{1'b0}}, 1'b1};
   assign len_ext = 32'(held_length_ff);
   assign idx_ext = 32'(emit_idx_ff);

   always_comb begin
      status.start1_match = (req_rx_byte == start_first_ff);
      status.start2_match = (req_rx_byte == start_second_ff);
      status.len_too_big = (req_rx_byte > BYTE_W'(MaxPayload));
      status.len_zero = (req_rx_byte == '0);
      status.data_done = (taken_next == {1'b0, held_length_ff});
      status.check1_ok = (req_rx_byte == sum_low_ff);
      status.check2_ok = (req_rx_byte == sum_high_ff);
      status.held_zero = (held_length_ff == '0);
      status.emit_last = empty_ff || (emit_next_idx == {1'b0, held_length_ff});
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff <= START_FIRST_RESET;
         start_second_ff <= START_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_FIRST: start_first_ff <= csr_data;
            CSR_START_SECOND: start_second_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_type) begin
         held_type_ff <= req_rx_byte;
         sum_low_ff <= req_rx_byte;
         sum_high_ff <= req_rx_byte;
      end else if (cmd.take_length || cmd.take_data) begin
         sum_low_ff <= sum_low_in;
         sum_high_ff <= sum_high_in;
      end
      if (cmd.take_length) begin
         held_length_ff <= req_rx_byte[LenW-1:0];
         taken_ff <= '0;
      end else if (cmd.take_data) begin
         taken_ff <= taken_next[LenW-1:0];
      end
      if (cmd.emit_start) begin
         emit_idx_ff <= '0;
         empty_ff <= (held_length_ff == '0);
      end else if (cmd.emit_next) begin
         emit_idx_ff <= emit_next_idx[LenW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_data) begin
         store[taken_ff[AddrW-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= store[emit_idx_ff[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_frame_type_ff <= held_type_ff;
         rsp_frame_length_ff <= len_ext[FRAME_LENGTH_W-1:0];
         rsp_byte_index_ff <= empty_ff ? '0 : idx_ext[BYTE_INDEX_W-1:0];
         rsp_payload_byte_ff <= empty_ff ? '0 : rd_data_ff;
         rsp_has_payload_ff <= !empty_ff;
         rsp_last_ff <= status.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_type = rsp_frame_type_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_byte_index = rsp_byte_index_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_has_payload = rsp_has_payload_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ===== rtl/core/fletcher_framed_packet_receiver_core.sv =====
// Top level of the framed packet receiver core with a Fletcher-8 check.
// Depends on ffpr_pkg, ffpr_ctrl and ffpr_datapath.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/stall     rx_byte
//   rsp_     out        rsp_valid/stall     frame_type, frame_length, byte_index,
//                                           payload_byte, has_payload, last
//   csr_     in         csr_write_enable    csr_index, csr_data
//
// While a frame is parsed, one input item is taken per cycle.
// A frame that passes its check is emitted one result at a time, each through
// the states EMIT_RD and EMIT_WR for the registered read of the payload memory;
// the input side is stalled meanwhile. A zero-length frame gives one result,
// straight from EMIT_WR. Reset is synchronous; no clearing pass is run.
// A stalled result register holds its item and pauses the emission.
module fletcher_framed_packet_receiver_core
   import ffpr_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [BYTE_W-1:0]         csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BYTE_W-1:0]         req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [BYTE_W-1:0]         rsp_frame_type,
   output logic [FRAME_LENGTH_W-1:0] rsp_frame_length,
   output logic [BYTE_INDEX_W-1:0]   rsp_byte_index,
   output logic [BYTE_W-1:0]         rsp_payload_byte,
   output logic                      rsp_has_payload,
   output logic                      rsp_last
);

   cmd_type    cmd;
   status_type status;

   ffpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ffpr_datapath #(
      .MaxPayload (MaxPayload)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/core/ffpr_checker.sv =====
// Port-level checker of the framed packet receiver core, bound to the top level.
// Depends on ffpr_pkg and the assertion macros in the defines header.
`include "fletcher_framed_packet_receiver_core_defines.svh"

module ffpr_checker
   import ffpr_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [FRAME_LENGTH_W-1:0] rsp_frame_length,
   input logic [BYTE_INDEX_W-1:0]   rsp_byte_index,
   input logic [BYTE_W-1:0]         rsp_payload_byte,
   input logic                      rsp_has_payload,
   input logic                      rsp_last
);

   `FFPR_ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `FFPR_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_byte_index) && $stable(rsp_last))
   `FFPR_ASSERT_SAME(a_empty_shape, clock, reset, rsp_valid && !rsp_has_payload,
      rsp_last && (rsp_byte_index == '0) && (rsp_payload_byte == '0) && (rsp_frame_length == '0))
   `FFPR_ASSERT_SAME(a_run_blocks_input, clock, reset, rsp_valid && rsp_has_payload && !rsp_last, req_stall)

endmodule

bind fletcher_framed_packet_receiver_core ffpr_checker u_ffpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_length (rsp_frame_length),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_has_payload  (rsp_has_payload),
   .rsp_last         (rsp_last)
);
